// ===== rtl/core/loss_and_gradient_unit_assert.svh =====
// assertion macros used by the port checker file
// each expands to one labeled concurrent assertion clocked on clk, held off in reset
`ifndef LOSS_AND_GRADIENT_UNIT_ASSERT_SVH
`define LOSS_AND_GRADIENT_UNIT_ASSERT_SVH

// same-cycle implication
`define LGU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LGU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lgu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgu_pkg
// shared constants, flag type and fixed-point helpers for the loss unit
// ----------------------------------------------------------------------------
package lgu_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam int IN_W   = 24;
    localparam int LOSS_W = 32;
    localparam int GRAD_W = 32;
    localparam int KIND_W = 3;
    localparam int Z_W    = 2 * IN_W;
    localparam int DF_W   = IN_W + 1;
    localparam int ROM_W  = 31;
    localparam int Q_BITS = 30;

    localparam longint Q_ONE = 64'sd1 <<< Q_BITS;

    localparam logic [KIND_W-1:0] KIND_LOGISTIC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HINGE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SQHINGE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SMOOTH   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SQERR    = 3'd4;

    typedef struct packed {
        logic big_pos;
        logic big_neg;
        logic above1;
        logic neg;
    } lgu_flag_t;

    // round half away from zero, drop sh bits
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic        neg;
        logic [63:0] mag;
        neg = v[63];
        mag = neg ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // shift toward zero
    function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = mag >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [LOSS_W-1:0] sat_loss(input logic signed [63:0] v);
        logic [LOSS_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > 64'sh0000_0000_FFFF_FFFF)
            r = '1;
        else
            r = v[LOSS_W-1:0];
        return r;
    endfunction

    function automatic logic [GRAD_W-1:0] sat_grad(input logic signed [63:0] v);
        logic [GRAD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[GRAD_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/loss_and_gradient_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_and_gradient_unit
// selectable loss (logistic, hinge, squared hinge, smooth hinge, squared
// error) and its derivative by the score, eight-stage pipeline
// ----------------------------------------------------------------------------
// One score/label transfer is taken per clock and one result per clock comes
// out while the output is not held. The whole pipeline advances together:
// while a result waits at the output with out_ready low, in_ready drops and
// nothing moves; nothing is dropped. The stage chain holds the score*label
// product, rounding, exp/log table read, interpolation multiply and
// sigmoid-by-label multiply. loss_kind is written through its own channel,
// always ready; each item uses the kind present when it was accepted.
// Logistic exp/log come from a constant table of TABLE_DEPTH+1 entries
// (TABLE_DEPTH a power of two) with linear interpolation. Both results
// saturate at their field limits.
// ----------------------------------------------------------------------------
module loss_and_gradient_unit
    import lgu_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [KIND_W-1:0]        loss_kind,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [IN_W-1:0]   score,
    input  logic signed [IN_W-1:0]   label,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LOSS_W-1:0]        loss_value,
    output logic signed [GRAD_W-1:0] gradient
);

    // table geometry: index = s >> SH, fraction = low SH bits
    localparam int TD_L   = $clog2(TABLE_DEPTH);
    localparam int IDX_W  = TD_L + 1;
    localparam int SH     = FRAC_BITS + 4 - TD_L;
    localparam int RW     = (SH > 0) ? SH : 1;
    localparam int PW     = 32 + RW + 1;
    // rounded |z|, one-minus-z and squaring operand widths
    localparam int SW     = 48 - FRAC_BITS;
    localparam int DW     = 51 - FRAC_BITS;
    localparam int DHI_W  = DW - IN_W;
    localparam int PL_W   = 2 * IN_W + 1;
    localparam int DQ     = (FRAC_BITS + 34) / 2;
    localparam int QW     = DQ + 1;
    localparam int LQ     = 2 * QW;
    localparam int LOG_SH = Q_BITS - FRAC_BITS;
    localparam int STAGES = 8;

    localparam longint ONE2     = 64'sd1 <<< (2 * FRAC_BITS);
    localparam longint HALF2    = ONE2 >>> 1;
    localparam longint LIM18    = 18 * ONE2;
    localparam longint LIM_IDX  = 64'sd16 <<< FRAC_BITS;
    localparam longint SQ_CAP   = 64'sd1 <<< DQ;
    localparam longint ROM_STEP = (64'sd16 <<< Q_BITS) / TABLE_DEPTH;

    typedef logic [ROM_W-1:0] rom_t [0:TABLE_DEPTH];

    // restoring long division for the table build, nonnegative operands
    function automatic longint udiv(input longint num, input longint den);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] nu;
        logic [63:0] dv;
        nu = 64'(num);
        dv = 64'(den);
        q  = '0;
        r  = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], nu[b]};
            if (r >= dv)
            begin
                r    = r - dv;
                q[b] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // exp(-x) stepped by repeated multiply, ln(1+u) via atanh series, u/(1+u)
    function automatic rom_t build_rom(input longint step, input bit want_g);
        rom_t   tbl;
        longint base;
        longint term;
        longint u;
        longint w;
        longint w2;
        longint p;
        longint acc;
        longint gv;
        base = Q_ONE;
        term = Q_ONE;
        u    = Q_ONE;
        for (int n = 1; n <= 12; n++)
        begin
            term = udiv((term * step + (Q_ONE >>> 1)) >>> Q_BITS, longint'(n));
            base = (n % 2 == 1) ? base - term : base + term;
        end
        for (int k = 0; k <= TABLE_DEPTH; k++)
        begin
            w   = udiv(u <<< Q_BITS, 2 * Q_ONE + u);
            w2  = (w * w + (Q_ONE >>> 1)) >>> Q_BITS;
            p   = w;
            acc = 0;
            for (int j = 0; j < 12; j++)
            begin
                acc = acc + udiv(p, longint'(2 * j + 1));
                p   = (p * w2 + (Q_ONE >>> 1)) >>> Q_BITS;
            end
            gv     = udiv((u <<< Q_BITS) + ((Q_ONE + u) >>> 1), Q_ONE + u);
            tbl[k] = want_g ? ROM_W'(gv) : ROM_W'(2 * acc);
            u      = (u * base + (Q_ONE >>> 1)) >>> Q_BITS;
        end
        return tbl;
    endfunction

    localparam rom_t ROM_F = build_rom(ROM_STEP, 1'b0);
    localparam rom_t ROM_G = build_rom(ROM_STEP, 1'b1);

    // ------------------------------------------------------------------
    // control: one valid bit per stage, common advance
    // ------------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [KIND_W-1:0] kind_cfg_reg;
    logic              adv;

    assign adv       = !vld_reg[STAGES-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[STAGES-1];
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            kind_cfg_reg <= KIND_LOGISTIC;
        end
        else
        begin
            if (adv)
                vld_reg <= vld_next;
            if (cfg_valid)
                kind_cfg_reg <= loss_kind;
        end
    end

    // ------------------------------------------------------------------
    // stage registers (payload)
    // ------------------------------------------------------------------
    // stage 1: z = a*y, a-y
    logic signed [Z_W-1:0]  zf_s1_reg, zf_s1_next;
    logic signed [DF_W-1:0] df_s1_reg, df_s1_next;
    logic signed [IN_W-1:0] y_s1_reg;
    logic [KIND_W-1:0]      kind_s1_reg;

    // stage 2: rounded forms and margin flags
    logic [SW-1:0]          s_s2_reg, s_s2_next;
    logic signed [DW-1:0]   d_s2_reg, d_s2_next;
    logic signed [DW-1:0]   dh_s2_reg, dh_s2_next;
    lgu_flag_t              flg_s2_reg, flg_s2_next;
    logic signed [IN_W-1:0] y_s2_reg;
    logic [KIND_W-1:0]      kind_s2_reg;
    logic signed [DF_W-1:0] df_s2_reg;
    logic signed [63:0]     zl;
    logic signed [63:0]     zabs;

    // stage 3: table read, square, label times one-minus-z partials
    logic [ROM_W-1:0]        f0_s3_reg, f0_s3_next;
    logic [ROM_W-1:0]        f1_s3_reg, f1_s3_next;
    logic [ROM_W-1:0]        g0_s3_reg, g0_s3_next;
    logic [ROM_W-1:0]        g1_s3_reg, g1_s3_next;
    logic [RW-1:0]           r_s3_reg, r_s3_next;
    logic [LQ-1:0]           sq_s3_reg, sq_s3_next;
    logic signed [PL_W-1:0]  pl_s3_reg, pl_s3_next;
    logic signed [DW-1:0]    ph_s3_reg, ph_s3_next;
    logic [SW-1:0]           s_s3_reg;
    logic signed [DW-1:0]    d_s3_reg;
    logic signed [DW-1:0]    dh_s3_reg;
    lgu_flag_t               flg_s3_reg;
    logic signed [IN_W-1:0]  y_s3_reg;
    logic [KIND_W-1:0]       kind_s3_reg;
    logic signed [DF_W-1:0]  df_s3_reg;
    logic                    idx_sat;
    logic [IDX_W-1:0]        idx0;
    logic [IDX_W-1:0]        idx1;
    logic [DF_W-1:0]         df_abs;
    logic [63:0]             sq_src;
    logic [QW-1:0]           sq_op;
    logic [IN_W-1:0]         d_lo;
    logic signed [DHI_W-1:0] d_hi;

    // stage 4: interpolation products, partial sum, squared loss
    logic signed [PW-1:0]   pf_s4_reg, pf_s4_next;
    logic signed [PW-1:0]   pg_s4_reg, pg_s4_next;
    logic [ROM_W-1:0]       f0_s4_reg;
    logic [ROM_W-1:0]       g0_s4_reg;
    logic signed [63:0]     gsum_s4_reg, gsum_s4_next;
    logic [LQ-1:0]          sql_s4_reg, sql_s4_next;
    logic [SW-1:0]          s_s4_reg;
    logic signed [DW-1:0]   d_s4_reg;
    logic signed [DW-1:0]   dh_s4_reg;
    lgu_flag_t              flg_s4_reg;
    logic signed [IN_W-1:0] y_s4_reg;
    logic [KIND_W-1:0]      kind_s4_reg;
    logic signed [DF_W-1:0] df_s4_reg;
    logic signed [31:0]     fd;
    logic signed [31:0]     gd;

    // stage 5: interpolated F and G, all non-logistic results final
    logic signed [31:0]     f_s5_reg, f_s5_next;
    logic signed [31:0]     g_s5_reg, g_s5_next;
    logic [LOSS_W-1:0]      lo_s5_reg, lo_s5_next;
    logic [GRAD_W-1:0]      go_s5_reg, go_s5_next;
    logic [SW-1:0]          s_s5_reg;
    lgu_flag_t              flg_s5_reg;
    logic signed [IN_W-1:0] y_s5_reg;
    logic [KIND_W-1:0]      kind_s5_reg;
    logic signed [63:0]     nl_loss;
    logic signed [63:0]     nl_grad;
    logic signed [63:0]     grad_sq;

    // stage 6: sigmoid and logistic loss
    logic signed [31:0]     sig_s6_reg, sig_s6_next;
    logic [LOSS_W-1:0]      ll_s6_reg, ll_s6_next;
    logic [LOSS_W-1:0]      lo_s6_reg;
    logic [GRAD_W-1:0]      go_s6_reg;
    logic [SW-1:0]          s_s6_reg;
    lgu_flag_t              flg_s6_reg;
    logic signed [IN_W-1:0] y_s6_reg;
    logic [KIND_W-1:0]      kind_s6_reg;
    logic signed [63:0]     ll_pre;

    // stage 7: label times sigmoid
    logic signed [IN_W+31:0] pr_s7_reg, pr_s7_next;
    logic [LOSS_W-1:0]       ll_s7_reg;
    logic [LOSS_W-1:0]       lo_s7_reg;
    logic [GRAD_W-1:0]       go_s7_reg;
    logic [SW-1:0]           s_s7_reg;
    lgu_flag_t               flg_s7_reg;
    logic signed [IN_W-1:0]  y_s7_reg;
    logic [KIND_W-1:0]       kind_s7_reg;

    // stage 8: output register
    logic [LOSS_W-1:0] loss_reg, loss_next;
    logic [GRAD_W-1:0] grad_reg, grad_next;

    // ------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------
    always_comb
    begin
        zf_s1_next = Z_W'(score) * Z_W'(label);
        df_s1_next = DF_W'(score) - DF_W'(label);
    end

    // ------------------------------------------------------------------
    // stage 2: all reductions round half away from zero
    // ------------------------------------------------------------------
    always_comb
    begin
        zl                  = 64'(zf_s1_reg);
        zabs                = (zl < 0) ? -zl : zl;
        s_s2_next           = SW'(round_shift(zabs, FRAC_BITS));
        d_s2_next           = DW'(round_shift(ONE2 - zl, FRAC_BITS));
        dh_s2_next          = DW'(round_shift(HALF2 - zl, FRAC_BITS));
        flg_s2_next.big_pos = zl > LIM18;
        flg_s2_next.big_neg = zl < -LIM18;
        flg_s2_next.above1  = zl > ONE2;
        flg_s2_next.neg     = zl < 0;
    end

    // ------------------------------------------------------------------
    // stage 3
    // ------------------------------------------------------------------
    always_comb
    begin
        // past the table end the last entry is used flat
        idx_sat = $signed(64'(s_s2_reg)) >= LIM_IDX;
        if (idx_sat)
        begin
            idx0      = IDX_W'(TABLE_DEPTH);
            idx1      = IDX_W'(TABLE_DEPTH);
            r_s3_next = '0;
        end
        else
        begin
            idx0      = IDX_W'(s_s2_reg >> SH);
            idx1      = idx0 + 1'b1;
            r_s3_next = (SH > 0) ? s_s2_reg[RW-1:0] : '0;
        end
        f0_s3_next = ROM_F[idx0];
        f1_s3_next = ROM_F[idx1];
        g0_s3_next = ROM_G[idx0];
        g1_s3_next = ROM_G[idx1];

        // squaring operand clamped where the loss saturates anyway
        df_abs = df_s2_reg[DF_W-1] ? DF_W'(-df_s2_reg) : DF_W'(df_s2_reg);
        if (kind_s2_reg == KIND_SQERR)
            sq_src = 64'(df_abs);
        else if (d_s2_reg < 0)
            sq_src = '0;
        else
            sq_src = 64'(d_s2_reg);
        sq_op      = ($signed(sq_src) >= SQ_CAP) ? QW'(SQ_CAP) : QW'(sq_src);
        sq_s3_next = LQ'(sq_op) * LQ'(sq_op);

        // label times (1-z) split into low and high partial products
        d_lo       = d_s2_reg[IN_W-1:0];
        d_hi       = d_s2_reg[DW-1:IN_W];
        pl_s3_next = PL_W'(y_s2_reg) * PL_W'($signed({1'b0, d_lo}));
        ph_s3_next = DW'(y_s2_reg) * DW'(d_hi);
    end

    // ------------------------------------------------------------------
    // stage 4
    // ------------------------------------------------------------------
    always_comb
    begin
        fd           = $signed({1'b0, f1_s3_reg}) - $signed({1'b0, f0_s3_reg});
        gd           = $signed({1'b0, g1_s3_reg}) - $signed({1'b0, g0_s3_reg});
        pf_s4_next   = PW'(fd) * PW'($signed({1'b0, r_s3_reg}));
        pg_s4_next   = PW'(gd) * PW'($signed({1'b0, r_s3_reg}));
        gsum_s4_next = (64'(ph_s3_reg) <<< IN_W) + 64'(pl_s3_reg);
        sql_s4_next  = LQ'(round_shift($signed(64'(sq_s3_reg)), FRAC_BITS + 1));
    end

    // ------------------------------------------------------------------
    // stage 5
    // ------------------------------------------------------------------
    always_comb
    begin
        // interpolation step truncates toward zero
        f_s5_next = 32'($signed({1'b0, f0_s4_reg})) + 32'(trunc_shift(64'(pf_s4_reg), SH));
        g_s5_next = 32'($signed({1'b0, g0_s4_reg})) + 32'(trunc_shift(64'(pg_s4_reg), SH));
        grad_sq   = -round_shift(gsum_s4_reg, FRAC_BITS);
        nl_loss   = '0;
        nl_grad   = '0;
        case (kind_s4_reg)
            KIND_HINGE:
            begin
                if (!flg_s4_reg.above1)
                begin
                    nl_loss = 64'(d_s4_reg);
                    nl_grad = -64'(y_s4_reg);
                end
            end
            KIND_SQHINGE:
            begin
                if (!flg_s4_reg.above1)
                begin
                    nl_loss = $signed(64'(sql_s4_reg));
                    nl_grad = grad_sq;
                end
            end
            KIND_SMOOTH:
            begin
                // linear below zero margin, quadratic up to one
                if (!flg_s4_reg.above1)
                begin
                    if (flg_s4_reg.neg)
                    begin
                        nl_loss = 64'(dh_s4_reg);
                        nl_grad = -64'(y_s4_reg);
                    end
                    else
                    begin
                        nl_loss = $signed(64'(sql_s4_reg));
                        nl_grad = grad_sq;
                    end
                end
            end
            KIND_SQERR:
            begin
                nl_loss = $signed(64'(sql_s4_reg));
                nl_grad = 64'(df_s4_reg);
            end
            default:
            begin
                nl_loss = '0;
                nl_grad = '0;
            end
        endcase
        lo_s5_next = sat_loss(nl_loss);
        go_s5_next = sat_grad(nl_grad);
    end

    // ------------------------------------------------------------------
    // stage 6: negative margin gives s + F(s) and 1 - G(s)
    // ------------------------------------------------------------------
    always_comb
    begin
        sig_s6_next = flg_s5_reg.neg ? 32'(Q_ONE) - g_s5_reg : g_s5_reg;
        ll_pre      = flg_s5_reg.neg ? ($signed(64'(s_s5_reg)) <<< LOG_SH) + 64'(f_s5_reg)
                                     : 64'(f_s5_reg);
        ll_s6_next  = sat_loss(round_shift(ll_pre, LOG_SH));
    end

    // ------------------------------------------------------------------
    // stage 7
    // ------------------------------------------------------------------
    always_comb
    begin
        pr_s7_next = (IN_W + 32)'(y_s6_reg) * (IN_W + 32)'(sig_s6_reg);
    end

    // ------------------------------------------------------------------
    // stage 8: logistic cut-offs and final pick
    // ------------------------------------------------------------------
    always_comb
    begin
        if (kind_s7_reg == KIND_LOGISTIC)
        begin
            if (flg_s7_reg.big_pos)
            begin
                loss_next = '0;
                grad_next = '0;
            end
            else if (flg_s7_reg.big_neg)
            begin
                loss_next = sat_loss($signed(64'(s_s7_reg)));
                grad_next = sat_grad(-64'(y_s7_reg));
            end
            else
            begin
                loss_next = ll_s7_reg;
                grad_next = sat_grad(-round_shift(64'(pr_s7_reg), Q_BITS));
            end
        end
        else
        begin
            loss_next = lo_s7_reg;
            grad_next = go_s7_reg;
        end
    end

    // ------------------------------------------------------------------
    // payload registers, moved on the common advance
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zf_s1_reg   <= zf_s1_next;
            df_s1_reg   <= df_s1_next;
            y_s1_reg    <= label;
            kind_s1_reg <= kind_cfg_reg;

            s_s2_reg    <= s_s2_next;
            d_s2_reg    <= d_s2_next;
            dh_s2_reg   <= dh_s2_next;
            flg_s2_reg  <= flg_s2_next;
            y_s2_reg    <= y_s1_reg;
            kind_s2_reg <= kind_s1_reg;
            df_s2_reg   <= df_s1_reg;

            f0_s3_reg   <= f0_s3_next;
            f1_s3_reg   <= f1_s3_next;
            g0_s3_reg   <= g0_s3_next;
            g1_s3_reg   <= g1_s3_next;
            r_s3_reg    <= r_s3_next;
            sq_s3_reg   <= sq_s3_next;
            pl_s3_reg   <= pl_s3_next;
            ph_s3_reg   <= ph_s3_next;
            s_s3_reg    <= s_s2_reg;
            d_s3_reg    <= d_s2_reg;
            dh_s3_reg   <= dh_s2_reg;
            flg_s3_reg  <= flg_s2_reg;
            y_s3_reg    <= y_s2_reg;
            kind_s3_reg <= kind_s2_reg;
            df_s3_reg   <= df_s2_reg;

            pf_s4_reg   <= pf_s4_next;
            pg_s4_reg   <= pg_s4_next;
            f0_s4_reg   <= f0_s3_reg;
            g0_s4_reg   <= g0_s3_reg;
            gsum_s4_reg <= gsum_s4_next;
            sql_s4_reg  <= sql_s4_next;
            s_s4_reg    <= s_s3_reg;
            d_s4_reg    <= d_s3_reg;
            dh_s4_reg   <= dh_s3_reg;
            flg_s4_reg  <= flg_s3_reg;
            y_s4_reg    <= y_s3_reg;
            kind_s4_reg <= kind_s3_reg;
            df_s4_reg   <= df_s3_reg;

            f_s5_reg    <= f_s5_next;
            g_s5_reg    <= g_s5_next;
            lo_s5_reg   <= lo_s5_next;
            go_s5_reg   <= go_s5_next;
            s_s5_reg    <= s_s4_reg;
            flg_s5_reg  <= flg_s4_reg;
            y_s5_reg    <= y_s4_reg;
            kind_s5_reg <= kind_s4_reg;

            sig_s6_reg  <= sig_s6_next;
            ll_s6_reg   <= ll_s6_next;
            lo_s6_reg   <= lo_s5_reg;
            go_s6_reg   <= go_s5_reg;
            s_s6_reg    <= s_s5_reg;
            flg_s6_reg  <= flg_s5_reg;
            y_s6_reg    <= y_s5_reg;
            kind_s6_reg <= kind_s5_reg;

            pr_s7_reg   <= pr_s7_next;
            ll_s7_reg   <= ll_s6_reg;
            lo_s7_reg   <= lo_s6_reg;
            go_s7_reg   <= go_s6_reg;
            s_s7_reg    <= s_s6_reg;
            flg_s7_reg  <= flg_s6_reg;
            y_s7_reg    <= y_s6_reg;
            kind_s7_reg <= kind_s6_reg;

            loss_reg    <= loss_next;
            grad_reg    <= grad_next;
        end
    end

    assign loss_value = loss_reg;
    assign gradient   = grad_reg;

endmodule

// ===== rtl/core/lgu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgu_port_checker
// port-level checks for the loss unit, bound to the top level
// ----------------------------------------------------------------------------
`include "loss_and_gradient_unit_assert.svh"

module lgu_port_checker
    import lgu_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic [KIND_W-1:0]        loss_kind,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [IN_W-1:0]   score,
    input logic signed [IN_W-1:0]   label,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [LOSS_W-1:0]        loss_value,
    input logic signed [GRAD_W-1:0] gradient
);

    // a held result keeps its value
    `LGU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(loss_value) && $stable(gradient), "held result changed")

    // empty output slot means the pipeline moves and takes input
    `LGU_ASSERT_SAME(a_empty_takes, !out_valid, in_ready, "input blocked with empty output")

    // a stalled result freezes the whole pipeline
    `LGU_ASSERT_SAME(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken during stall")

endmodule

bind loss_and_gradient_unit lgu_port_checker u_lgu_port_checker (.*);

// ===== sim/lgu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgu_checker
// watches the loss unit channels, predicts each result and compares it
// ----------------------------------------------------------------------------
module lgu_checker
    import lgu_pkg::*;
#(
    parameter int FB = 16,
    parameter int TD = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [KIND_W-1:0]        loss_kind,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [IN_W-1:0]   score,
    input  logic signed [IN_W-1:0]   label,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [LOSS_W-1:0]        loss_value,
    input  logic signed [GRAD_W-1:0] gradient,
    output int                       errors,
    output int                       pending
);

    typedef struct {
        logic [LOSS_W-1:0] loss;
        logic [GRAD_W-1:0] grad;
    } loss_grad_t;

    longint            ln_tab [0:TD];
    longint            sig_tab[0:TD];
    logic [KIND_W-1:0] cur_kind;
    loss_grad_t        expected_q[$];

    function automatic longint round_away(input longint v, input int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    // exp/log table: u = exp(-x) by stepping, ln(1+u) via atanh series
    initial
    begin
        longint h, base, term, u, w, w2, p, acc;
        longint half;
        half = Q_ONE >>> 1;
        h    = (longint'(16) <<< 30) / TD;
        base = Q_ONE;
        term = Q_ONE;
        u    = Q_ONE;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * h + half) >>> 30) / n;
            base = (n % 2 == 1) ? base - term : base + term;
        end
        for (int k = 0; k <= TD; k++)
        begin
            w   = (u <<< 30) / (2 * Q_ONE + u);
            w2  = (w * w + half) >>> 30;
            p   = w;
            acc = 0;
            for (int j = 0; j < 12; j++)
            begin
                acc = acc + p / (2 * j + 1);
                p   = (p * w2 + half) >>> 30;
            end
            ln_tab[k]  = 2 * acc;
            sig_tab[k] = ((u <<< 30) + ((Q_ONE + u) >>> 1)) / (Q_ONE + u);
            u = (u * base + half) >>> 30;
        end
    end

    function automatic loss_grad_t predict_loss(input logic [KIND_W-1:0] kind,
                                                input longint a, input longint y);
        loss_grad_t r;
        longint     zf, one2, loss, grad, s, fv, gv, sig, d, span, pos, idx, rem;
        zf   = a * y;
        one2 = longint'(1) <<< (2 * FB);
        loss = 0;
        grad = 0;
        case (kind)
            KIND_LOGISTIC:
            begin
                if (zf > 18 * one2)
                begin
                    loss = 0;
                    grad = 0;
                end
                else if (zf < -18 * one2)
                begin
                    loss = round_away(-zf, FB);
                    grad = -y;
                end
                else
                begin
                    s    = round_away((zf < 0) ? -zf : zf, FB);
                    span = longint'(16) <<< FB;
                    pos  = s * TD;
                    idx  = pos / span;
                    rem  = pos % span;
                    if (idx >= TD)
                    begin
                        fv = ln_tab[TD];
                        gv = sig_tab[TD];
                    end
                    else
                    begin
                        fv = ln_tab[idx] + ((ln_tab[idx+1] - ln_tab[idx]) * rem) / span;
                        gv = sig_tab[idx] + ((sig_tab[idx+1] - sig_tab[idx]) * rem) / span;
                    end
                    if (zf < 0)
                    begin
                        loss = round_away((s <<< (30 - FB)) + fv, 30 - FB);
                        sig  = Q_ONE - gv;
                    end
                    else
                    begin
                        loss = round_away(fv, 30 - FB);
                        sig  = gv;
                    end
                    grad = round_away(-y * sig, 30);
                end
            end
            KIND_HINGE:
            begin
                if (zf <= one2)
                begin
                    loss = round_away(one2 - zf, FB);
                    grad = -y;
                end
            end
            KIND_SQHINGE, KIND_SMOOTH:
            begin
                if (zf <= one2)
                begin
                    if (kind == KIND_SMOOTH && zf < 0)
                    begin
                        loss = round_away(one2 / 2 - zf, FB);
                        grad = -y;
                    end
                    else
                    begin
                        d    = round_away(one2 - zf, FB);
                        loss = round_away(d * d, FB + 1);
                        grad = round_away(-y * d, FB);
                    end
                end
            end
            KIND_SQERR:
            begin
                d    = a - y;
                loss = round_away(d * d, FB + 1);
                grad = d;
            end
            default:
            begin
                loss = 0;
                grad = 0;
            end
        endcase
        // clamp to field limits
        if (loss < 0)
            loss = 0;
        else if (loss > 64'sh0000_0000_FFFF_FFFF)
            loss = 64'sh0000_0000_FFFF_FFFF;
        if (grad > 64'sd2147483647)
            grad = 64'sd2147483647;
        else if (grad < -64'sd2147483648)
            grad = -64'sd2147483648;
        r.loss = loss[LOSS_W-1:0];
        r.grad = grad[GRAD_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        loss_grad_t want;
        if (!rst_n)
        begin
            cur_kind <= KIND_LOGISTIC;
            errors   <= 0;
            pending  <= 0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result loss=%h grad=%h",
                             $time, loss_value, gradient);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.loss !== loss_value || want.grad !== gradient)
                    begin
                        if (want.loss !== loss_value)
                            $display("%0t: loss_value expected %h actual %h",
                                     $time, want.loss, loss_value);
                        if (want.grad !== gradient)
                            $display("%0t: gradient expected %h actual %h",
                                     $time, want.grad, gradient);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_loss(cur_kind, longint'(score),
                                                  longint'(label)));
            if (cfg_valid && cfg_ready)
                cur_kind <= loss_kind;
            pending <= expected_q.size();
        end
    end

endmodule

// ===== sim/loss_and_gradient_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_and_gradient_unit_tb
// directed and random score/label streams under every loss kind, with
// random gaps on both channels; a separate checker predicts and compares
// ----------------------------------------------------------------------------
module loss_and_gradient_unit_tb;
    import lgu_pkg::*;

    localparam int ONE_Q     = 65536;      // 1.0 in Q8.16
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 16;         // pipeline is eight deep
    localparam int PHASES    = 12;
    localparam int PER_PHASE = 138;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [KIND_W-1:0]        loss_kind;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [IN_W-1:0]   score;
    logic signed [IN_W-1:0]   label;
    logic                     out_valid;
    logic                     out_ready;
    logic [LOSS_W-1:0]        loss_value;
    logic signed [GRAD_W-1:0] gradient;
    int                       errors;
    int                       pending;
    int                       cycles = 0;
    bit                       no_gaps;     // stretches with no idling on either side

    loss_and_gradient_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .loss_kind  (loss_kind),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .score      (score),
        .label      (label),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .loss_value (loss_value),
        .gradient   (gradient)
    );

    lgu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .loss_kind  (loss_kind),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .score      (score),
        .label      (label),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .loss_value (loss_value),
        .gradient   (gradient),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // run limit, well above the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall before each result transfer
    initial
    begin
        int g;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            g = no_gaps ? 0 : $urandom_range(0, 11);
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // one register write, only while the unit is idle
    task automatic write_kind(input logic [KIND_W-1:0] k);
        cfg_valid <= 1'b1;
        loss_kind <= k;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one score/label transfer after a random gap
    task automatic send_pair(input logic [IN_W-1:0] s, input logic [IN_W-1:0] l);
        int g;
        g = no_gaps ? 0 : $urandom_range(0, 11);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        score    <= s;
        label    <= l;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold off until every expected result is back, then let the pipe settle
    task automatic drain_results;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // mostly +-1 labels with scores around the margins, some noise
    function automatic logic [IN_W-1:0] rand_label;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return ($urandom_range(0, 1) == 1) ? IN_W'(ONE_Q) : IN_W'(-ONE_Q);
        else if (r < 8)
            return IN_W'($signed($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q);
        return IN_W'($urandom);
    endfunction

    function automatic logic [IN_W-1:0] rand_score;
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return IN_W'($signed($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q);
        else if (r < 8)
            return IN_W'($signed($urandom_range(0, 40 * ONE_Q)) - 20 * ONE_Q);
        return IN_W'($urandom);
    endfunction

    logic [KIND_W-1:0] dir_kinds[5];

    initial
    begin
        logic [KIND_W-1:0] k;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        loss_kind = '0;
        in_valid  = 1'b0;
        score     = '0;
        label     = '0;
        no_gaps   = 1'b0;
        dir_kinds = '{KIND_LOGISTIC, KIND_HINGE, KIND_SQHINGE, KIND_SMOOTH, KIND_SQERR};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, margin exactly one, and both logistic cut-offs
        foreach (dir_kinds[i])
        begin
            write_kind(dir_kinds[i]);
            send_pair(24'h7FFFFF, 24'h800000);
            send_pair(24'h800000, 24'h800000);
            send_pair(IN_W'(ONE_Q), IN_W'(ONE_Q));
            send_pair(IN_W'(18 * ONE_Q + 1), IN_W'(ONE_Q));
            send_pair(IN_W'(-18 * ONE_Q - 1), IN_W'(ONE_Q));
            drain_results();
        end

        // random phases sweep every register value, unused kinds included
        for (int p = 0; p < PHASES; p++)
        begin
            k = KIND_W'((p * 3) % 8);
            write_kind(k);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                if (i % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_pair(rand_score(), rand_label());
            end
            no_gaps = 1'b0;
            drain_results();
        end

        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== loss_and_gradient_unit.f =====
+incdir+rtl/core
rtl/core/lgu_pkg.sv
rtl/core/loss_and_gradient_unit.sv
rtl/core/lgu_checker.sv
sim/lgu_checker.sv
sim/loss_and_gradient_unit_tb.sv
